/* rtl/gasp_pkg.sv */
// ----------------------------------------------------------------------------
// Grid path search package
// Shared map geometry, cell record layout and result codes.
// ----------------------------------------------------------------------------
package gasp_pkg;

   // Map geometry. The width is a power of two, so a cell index is {y, x}.
   localparam int MAP_W = 32;
   localparam int MAP_H = 32;
   localparam int CELLS = MAP_W * MAP_H;
   localparam int X_W   = $clog2(MAP_W);
   localparam int Y_W   = $clog2(MAP_H);
   localparam int IDX_W = X_W + Y_W;
   localparam int G_W   = 10;
   localparam int F_W   = G_W + 1;

   // Search mark of one cell.
   localparam logic [1:0] MARK_NONE   = 2'd0;
   localparam logic [1:0] MARK_OPEN   = 2'd1;
   localparam logic [1:0] MARK_CLOSED = 2'd2;

   // Step directions in successor order.
   localparam logic [1:0] DIR_XP = 2'd0;
   localparam logic [1:0] DIR_XN = 2'd1;
   localparam logic [1:0] DIR_YP = 2'd2;
   localparam logic [1:0] DIR_YN = 2'd3;

   // Result status codes.
   localparam logic [1:0] STAT_FOUND   = 2'd0;
   localparam logic [1:0] STAT_AT_GOAL = 2'd1;
   localparam logic [1:0] STAT_NO_PATH = 2'd2;

   // Request function codes.
   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   // Per-cell search record.
   typedef struct packed {
      logic [1:0]     mark;
      logic [G_W-1:0] cost;
      logic [1:0]     parent;
   } cell_word_type;

   // Write port of the cell record store.
   typedef struct packed {
      logic               en;
      logic [IDX_W-1:0]   addr;
      cell_word_type      data;
   } cell_wr_type;

   // Write port of the blocked-cell map.
   typedef struct packed {
      logic               en;
      logic [IDX_W-1:0]   addr;
      logic               bit_val;
   } blk_wr_type;

endpackage

/* rtl/grid_astar_path_search.sv */
// ----------------------------------------------------------------------------
// Grid A* path search
// A* search with Manhattan heuristic over a stored 4-connected blocked map.
// ----------------------------------------------------------------------------
// After reset the block clears its blocked map one cell a cycle, so the map
// reads as an open grid. The input stays stalled while the map is cleared. A
// map write is done in the idle state. A query whose start equals its goal
// goes straight to the result. Any other query first sweeps the search
// records (one cell a cycle through the single memory port). Then, for every
// expanded cell, it scans all 1024 records for the lowest f, closes the cell
// and steps through its successors. Once the goal is generated, the path is
// walked back through the trace and trace-wait states to find the first
// step. The block stalls its input for the whole query.
module grid_astar_path_search (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_func,
   input  logic [4:0]                  req_cell_x,
   input  logic [4:0]                  req_cell_y,
   input  logic [4:0]                  req_goal_x,
   input  logic [4:0]                  req_goal_y,
   input  logic                        req_blocked,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [1:0]                  rsp_status,
   output logic [9:0]                  rsp_path_length,
   output logic [4:0]                  rsp_first_x,
   output logic [4:0]                  rsp_first_y
);

   localparam int IW = gasp_pkg::IDX_W;
   localparam int XW = gasp_pkg::X_W;
   localparam int YW = gasp_pkg::Y_W;
   localparam int GW = gasp_pkg::G_W;
   localparam int FW = gasp_pkg::F_W;
   localparam logic [IW:0] CELL_END = (IW+1)'(gasp_pkg::CELLS - 1);

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_CLEAR  = 4'd1;
   localparam logic [3:0] ST_SEED   = 4'd2;
   localparam logic [3:0] ST_SCAN   = 4'd3;
   localparam logic [3:0] ST_PICK   = 4'd4;
   localparam logic [3:0] ST_CLOSE  = 4'd5;
   localparam logic [3:0] ST_STEP   = 4'd6;
   localparam logic [3:0] ST_NEVAL  = 4'd7;
   localparam logic [3:0] ST_TRACE  = 4'd8;
   localparam logic [3:0] ST_TWAIT  = 4'd9;
   localparam logic [3:0] ST_RESULT = 4'd10;
   localparam logic [3:0] ST_WIPE   = 4'd11;

   logic [3:0]    state_ff, state_in;
   logic [IW:0]   cnt_ff, cnt_in;
   logic          scan_v_ff, scan_v_in;
   logic [IW-1:0] scan_idx_ff, scan_idx_in;
   logic          best_v_ff, best_v_in;
   logic [IW-1:0] best_idx_ff, best_idx_in;
   logic [FW-1:0] best_f_ff, best_f_in;
   logic [GW-1:0] best_g_ff, best_g_in;
   logic [1:0]    best_par_ff, best_par_in;
   logic [1:0]    dir_ff, dir_in;
   logic [GW-1:0] ng_ff, ng_in;
   logic [IW-1:0] nidx_ff, nidx_in;
   logic [XW-1:0] goal_x_ff, goal_x_in;
   logic [YW-1:0] goal_y_ff, goal_y_in;
   logic [IW-1:0] start_ff, start_in;
   logic [IW-1:0] cur_ff, cur_in;
   logic [1:0]    res_stat_ff, res_stat_in;
   logic [9:0]    res_len_ff, res_len_in;
   logic [4:0]    res_fx_ff, res_fx_in;
   logic [4:0]    res_fy_ff, res_fy_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [1:0]    rsp_stat_ff, rsp_stat_in;
   logic [9:0]    rsp_len_ff, rsp_len_in;
   logic [4:0]    rsp_fx_ff, rsp_fx_in;
   logic [4:0]    rsp_fy_ff, rsp_fy_in;

   logic [IW-1:0]           rd_addr;
   gasp_pkg::cell_wr_type   cell_wr;
   gasp_pkg::blk_wr_type    blk_wr;
   gasp_pkg::cell_word_type cell_rd;
   logic                    blk_rd;

   gasp_store u_store (
      .clock      (clock),
      .rd_addr    (rd_addr),
      .cell_wr    (cell_wr),
      .blk_wr     (blk_wr),
      .cell_rd_ff (cell_rd),
      .blk_rd_ff  (blk_rd)
   );

   // Coordinates of the scanned cell and its f value.
   logic [XW-1:0] sc_x;
   logic [YW-1:0] sc_y;
   logic [XW-1:0] dx_abs;
   logic [YW-1:0] dy_abs;
   logic [FW-1:0] sc_f;

   assign sc_x   = scan_idx_ff[XW-1:0];
   assign sc_y   = scan_idx_ff[IW-1:XW];
   assign dx_abs = (sc_x > goal_x_ff) ? sc_x - goal_x_ff : goal_x_ff - sc_x;
   assign dy_abs = (sc_y > goal_y_ff) ? sc_y - goal_y_ff : goal_y_ff - sc_y;
   assign sc_f   = FW'(cell_rd.cost) + FW'(dx_abs) + FW'(dy_abs);

   // Successor of the expanded cell; one extra bit flags a step off the map.
   logic [XW:0] q_x, n_x;
   logic [YW:0] q_y, n_y;
   logic        n_on_map, n_goal;

   assign q_x = {1'b0, best_idx_ff[XW-1:0]};
   assign q_y = {1'b0, best_idx_ff[IW-1:XW]};

   always_comb begin
      n_x = q_x;
      n_y = q_y;
      unique case (dir_ff)
         gasp_pkg::DIR_XP: n_x = q_x + 1'b1;
         gasp_pkg::DIR_XN: n_x = q_x - 1'b1;
         gasp_pkg::DIR_YP: n_y = q_y + 1'b1;
         gasp_pkg::DIR_YN: n_y = q_y - 1'b1;
      endcase
   end

   assign n_on_map = (n_x < (XW+1)'(gasp_pkg::MAP_W)) && (n_y < (YW+1)'(gasp_pkg::MAP_H));
   assign n_goal   = (n_x == {1'b0, goal_x_ff}) && (n_y == {1'b0, goal_y_ff});

   // Parent of the traced cell, undoing the stored step.
   logic [XW:0] c_x, p_x;
   logic [YW:0] c_y, p_y;
   logic        p_on_map;

   assign c_x = {1'b0, cur_ff[XW-1:0]};
   assign c_y = {1'b0, cur_ff[IW-1:XW]};

   always_comb begin
      p_x = c_x;
      p_y = c_y;
      unique case (cell_rd.parent)
         gasp_pkg::DIR_XP: p_x = c_x - 1'b1;
         gasp_pkg::DIR_XN: p_x = c_x + 1'b1;
         gasp_pkg::DIR_YP: p_y = c_y - 1'b1;
         gasp_pkg::DIR_YN: p_y = c_y + 1'b1;
      endcase
   end

   assign p_on_map = (p_x < (XW+1)'(gasp_pkg::MAP_W)) && (p_y < (YW+1)'(gasp_pkg::MAP_H));

   // Path length on reaching the goal, saturated to the field width.
   logic [GW:0] len_full;
   assign len_full = {1'b0, best_g_ff} + 1'b1;

   logic out_free;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);

   // Search sequencer.
   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      scan_v_in   = 1'b0;
      scan_idx_in = scan_idx_ff;
      best_v_in   = best_v_ff;
      best_idx_in = best_idx_ff;
      best_f_in   = best_f_ff;
      best_g_in   = best_g_ff;
      best_par_in = best_par_ff;
      dir_in      = dir_ff;
      ng_in       = ng_ff;
      nidx_in     = nidx_ff;
      goal_x_in   = goal_x_ff;
      goal_y_in   = goal_y_ff;
      start_in    = start_ff;
      cur_in      = cur_ff;
      res_stat_in = res_stat_ff;
      res_len_in  = res_len_ff;
      res_fx_in   = res_fx_ff;
      res_fy_in   = res_fy_ff;
      rd_addr     = cnt_ff[IW-1:0];
      cell_wr     = '0;
      blk_wr      = '0;

      unique case (state_ff)
         ST_WIPE: begin
            // Clear the blocked map after reset, one cell a cycle.
            blk_wr.en      = 1'b1;
            blk_wr.addr    = cnt_ff[IW-1:0];
            blk_wr.bit_val = 1'b0;
            cnt_in         = cnt_ff + 1'b1;
            if (cnt_ff == CELL_END) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               if (req_func == gasp_pkg::FUNC_WRITE) begin
                  blk_wr.en      = 1'b1;
                  blk_wr.addr    = {req_cell_y, req_cell_x};
                  blk_wr.bit_val = req_blocked;
               end else begin
                  goal_x_in   = req_goal_x;
                  goal_y_in   = req_goal_y;
                  start_in    = {req_cell_y, req_cell_x};
                  res_len_in  = '0;
                  res_fx_in   = '0;
                  res_fy_in   = '0;
                  cnt_in      = '0;
                  if (req_cell_x == req_goal_x && req_cell_y == req_goal_y) begin
                     res_stat_in = gasp_pkg::STAT_AT_GOAL;
                     state_in    = ST_RESULT;
                  end else begin
                     state_in = ST_CLEAR;
                  end
               end
            end
         end
         ST_CLEAR: begin
            cell_wr.en   = 1'b1;
            cell_wr.addr = cnt_ff[IW-1:0];
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == CELL_END) begin
               state_in = ST_SEED;
            end
         end
         ST_SEED: begin
            cell_wr.en        = 1'b1;
            cell_wr.addr      = start_ff;
            cell_wr.data.mark = gasp_pkg::MARK_OPEN;
            cnt_in            = '0;
            best_v_in         = 1'b0;
            state_in          = ST_SCAN;
         end
         ST_SCAN: begin
            // Issue one read a cycle, judge the cell read the cycle before.
            if (!cnt_ff[IW]) begin
               scan_v_in   = 1'b1;
               scan_idx_in = cnt_ff[IW-1:0];
               cnt_in      = cnt_ff + 1'b1;
            end
            if (scan_v_ff && cell_rd.mark == gasp_pkg::MARK_OPEN &&
                (!best_v_ff || sc_f < best_f_ff)) begin
               best_v_in   = 1'b1;
               best_idx_in = scan_idx_ff;
               best_f_in   = sc_f;
               best_g_in   = cell_rd.cost;
               best_par_in = cell_rd.parent;
            end
            if (scan_v_ff && scan_idx_ff == CELL_END[IW-1:0]) begin
               state_in = ST_PICK;
            end
         end
         ST_PICK: begin
            if (best_v_ff) begin
               state_in = ST_CLOSE;
            end else begin
               res_stat_in = gasp_pkg::STAT_NO_PATH;
               state_in    = ST_RESULT;
            end
         end
         ST_CLOSE: begin
            cell_wr.en          = 1'b1;
            cell_wr.addr        = best_idx_ff;
            cell_wr.data.mark   = gasp_pkg::MARK_CLOSED;
            cell_wr.data.cost   = best_g_ff;
            cell_wr.data.parent = best_par_ff;
            dir_in              = gasp_pkg::DIR_XP;
            ng_in               = len_full[GW-1:0];
            state_in            = ST_STEP;
         end
         ST_STEP: begin
            rd_addr = {n_y[YW-1:0], n_x[XW-1:0]};
            nidx_in = {n_y[YW-1:0], n_x[XW-1:0]};
            if (n_goal) begin
               res_stat_in = gasp_pkg::STAT_FOUND;
               res_len_in  = len_full[GW] ? 10'h3ff : 10'(len_full[GW-1:0]);
               res_fx_in   = 5'(goal_x_ff);
               res_fy_in   = 5'(goal_y_ff);
               cur_in      = best_idx_ff;
               state_in    = ST_TRACE;
            end else if (n_on_map) begin
               state_in = ST_NEVAL;
            end else if (dir_ff == gasp_pkg::DIR_YN) begin
               cnt_in    = '0;
               best_v_in = 1'b0;
               state_in  = ST_SCAN;
            end else begin
               dir_in = dir_ff + 1'b1;
            end
         end
         ST_NEVAL: begin
            // Open or improve the successor unless blocked, closed or better.
            if (!blk_rd && cell_rd.mark != gasp_pkg::MARK_CLOSED &&
                !(cell_rd.mark == gasp_pkg::MARK_OPEN && cell_rd.cost < ng_ff)) begin
               cell_wr.en          = 1'b1;
               cell_wr.addr        = nidx_ff;
               cell_wr.data.mark   = gasp_pkg::MARK_OPEN;
               cell_wr.data.cost   = ng_ff;
               cell_wr.data.parent = dir_ff;
            end
            if (dir_ff == gasp_pkg::DIR_YN) begin
               cnt_in    = '0;
               best_v_in = 1'b0;
               state_in  = ST_SCAN;
            end else begin
               dir_in   = dir_ff + 1'b1;
               state_in = ST_STEP;
            end
         end
         ST_TRACE: begin
            rd_addr = cur_ff;
            if (cur_ff == start_ff) begin
               state_in = ST_RESULT;
            end else begin
               res_fx_in = 5'(cur_ff[XW-1:0]);
               res_fy_in = 5'(cur_ff[IW-1:XW]);
               state_in  = ST_TWAIT;
            end
         end
         ST_TWAIT: begin
            if (p_on_map) begin
               cur_in   = {p_y[YW-1:0], p_x[XW-1:0]};
               state_in = ST_TRACE;
            end else begin
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output register: loads a finished result, clears on transfer.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_stat_in  = rsp_stat_ff;
      rsp_len_in   = rsp_len_ff;
      rsp_fx_in    = rsp_fx_ff;
      rsp_fy_in    = rsp_fy_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (state_ff == ST_RESULT && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_stat_in  = res_stat_ff;
         rsp_len_in   = res_len_ff;
         rsp_fx_in    = res_fx_ff;
         rsp_fy_in    = res_fy_ff;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_WIPE;
         cnt_ff       <= '0;
         scan_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         scan_v_ff    <= scan_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      scan_idx_ff <= scan_idx_in;
      best_v_ff   <= best_v_in;
      best_idx_ff <= best_idx_in;
      best_f_ff   <= best_f_in;
      best_g_ff   <= best_g_in;
      best_par_ff <= best_par_in;
      dir_ff      <= dir_in;
      ng_ff       <= ng_in;
      nidx_ff     <= nidx_in;
      goal_x_ff   <= goal_x_in;
      goal_y_ff   <= goal_y_in;
      start_ff    <= start_in;
      cur_ff      <= cur_in;
      res_stat_ff <= res_stat_in;
      res_len_ff  <= res_len_in;
      res_fx_ff   <= res_fx_in;
      res_fy_ff   <= res_fy_in;
      rsp_stat_ff <= rsp_stat_in;
      rsp_len_ff  <= rsp_len_in;
      rsp_fx_ff   <= rsp_fx_in;
      rsp_fy_ff   <= rsp_fy_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_stat_ff;
   assign rsp_path_length = rsp_len_ff;
   assign rsp_first_x     = rsp_fx_ff;
   assign rsp_first_y     = rsp_fy_ff;

   // A found path always has at least one step.
   a_found_len : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == gasp_pkg::STAT_FOUND) |-> (rsp_path_length != 10'd0))
      else $error("found path reported with zero length");

   // Results other than a found path carry zero fields.
   a_empty_fields : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != gasp_pkg::STAT_FOUND) |->
      (rsp_path_length == 10'd0 && rsp_first_x == 5'd0 && rsp_first_y == 5'd0))
      else $error("non-path result carries path fields");

   // A successor is opened with the expanded cell's cost plus one.
   a_open_cost : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_NEVAL && cell_wr.en) |-> (cell_wr.data.cost == GW'(best_g_ff + 1'b1)))
      else $error("successor opened with wrong cost");

   // The request side stays stalled until a query result has been loaded.
   a_busy_until_result : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RESULT && !out_free) |=> req_stall)
      else $error("request accepted while a result was pending");

endmodule

/* rtl/gasp_store.sv */
// ----------------------------------------------------------------------------
// Grid path search storage
// Blocked-cell map and per-cell search records, one shared read address.
// ----------------------------------------------------------------------------
module gasp_store (
   input  logic                          clock,
   input  logic [gasp_pkg::IDX_W-1:0]    rd_addr,
   input  gasp_pkg::cell_wr_type         cell_wr,
   input  gasp_pkg::blk_wr_type          blk_wr,
   output gasp_pkg::cell_word_type       cell_rd_ff,
   output logic                          blk_rd_ff
);

   gasp_pkg::cell_word_type cell_mem [gasp_pkg::CELLS];
   logic                    blk_mem  [gasp_pkg::CELLS];

   // Search record memory with registered read.
   always_ff @(posedge clock) begin
      if (cell_wr.en) begin
         cell_mem[cell_wr.addr] <= cell_wr.data;
      end
      cell_rd_ff <= cell_mem[rd_addr];
   end

   // Blocked-cell map memory with registered read.
   always_ff @(posedge clock) begin
      if (blk_wr.en) begin
         blk_mem[blk_wr.addr] <= blk_wr.bit_val;
      end
      blk_rd_ff <= blk_mem[rd_addr];
   end

endmodule

/* dv/grid_astar_path_search_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid path search checker
// Watches both channels of the grid path search block. Every accepted map
// write updates a private copy of the blocked map, and every accepted query is
// run through an A* search of its own to predict the result. Accepted results
// are compared field by field, in order, with the predicted ones.
// ----------------------------------------------------------------------------
module grid_astar_path_search_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic       req_func,
   input  logic [4:0] req_cell_x,
   input  logic [4:0] req_cell_y,
   input  logic [4:0] req_goal_x,
   input  logic [4:0] req_goal_y,
   input  logic       req_blocked,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic [1:0] rsp_status,
   input  logic [9:0] rsp_path_length,
   input  logic [4:0] rsp_first_x,
   input  logic [4:0] rsp_first_y,
   output int         fail_count,
   output int         pending
);

   typedef struct {
      logic [1:0] status;
      logic [9:0] path_length;
      logic [4:0] first_x;
      logic [4:0] first_y;
   } route_type;

   // Private search state.
   bit wall_map  [gasp_pkg::CELLS];
   bit open_flag [gasp_pkg::CELLS];
   bit done_flag [gasp_pkg::CELLS];
   int g_cost    [gasp_pkg::CELLS];
   int came_dir  [gasp_pkg::CELLS];

   route_type route_queue[$];

   const int step_x[4] = '{1, -1, 0, 0};
   const int step_y[4] = '{0, 0, 1, -1};

   function automatic bit inside_map(int x, int y);
      return x >= 0 && y >= 0 && x < gasp_pkg::MAP_W && y < gasp_pkg::MAP_H;
   endfunction

   function automatic int manhattan(int x, int y, int gx, int gy);
      return (x > gx ? x - gx : gx - x) + (y > gy ? y - gy : gy - y);
   endfunction

   // A* search with lowest-f, lowest-index selection; the goal is taken as
   // soon as it is generated.
   function automatic route_type search_route(int sx, int sy, int gx, int gy);
      route_type r;
      int start_idx, open_n, best, best_f, f, qx, qy, nx, ny, ni, ng, nf;
      int cur, fx, fy, guard, cx, cy, px, py, len;
      r.status = gasp_pkg::STAT_NO_PATH;
      r.path_length = '0;
      r.first_x = '0;
      r.first_y = '0;
      if (sx == gx && sy == gy) begin
         r.status = gasp_pkg::STAT_AT_GOAL;
         return r;
      end
      if (!inside_map(sx, sy)) return r;
      foreach (open_flag[i]) begin
         open_flag[i] = 0;
         done_flag[i] = 0;
      end
      start_idx = sy * gasp_pkg::MAP_W + sx;
      open_flag[start_idx] = 1;
      g_cost[start_idx] = 0;
      came_dir[start_idx] = 0;
      open_n = 1;
      while (open_n > 0) begin
         best = -1;
         best_f = 0;
         for (int i = 0; i < gasp_pkg::CELLS; i++) begin
            if (open_flag[i]) begin
               f = g_cost[i] + manhattan(i % gasp_pkg::MAP_W, i / gasp_pkg::MAP_W, gx, gy);
               if (best < 0 || f < best_f) begin
                  best = i;
                  best_f = f;
               end
            end
         end
         if (best < 0) break;
         open_flag[best] = 0;
         open_n--;
         qx = best % gasp_pkg::MAP_W;
         qy = best / gasp_pkg::MAP_W;
         for (int d = 0; d < 4; d++) begin
            nx = qx + step_x[d];
            ny = qy + step_y[d];
            if (nx == gx && ny == gy) begin
               // Walk the parent chain back to the cell after the start.
               len = g_cost[best] + 1;
               fx = gx;
               fy = gy;
               cur = best;
               guard = 0;
               while (cur != start_idx && guard < gasp_pkg::CELLS) begin
                  cx = cur % gasp_pkg::MAP_W;
                  cy = cur / gasp_pkg::MAP_W;
                  px = cx - step_x[came_dir[cur]];
                  py = cy - step_y[came_dir[cur]];
                  fx = cx;
                  fy = cy;
                  if (!inside_map(px, py)) break;
                  cur = py * gasp_pkg::MAP_W + px;
                  guard++;
               end
               r.status = gasp_pkg::STAT_FOUND;
               r.path_length = len > 1023 ? 10'd1023 : 10'(len);
               r.first_x = 5'(fx);
               r.first_y = 5'(fy);
               return r;
            end
            if (!inside_map(nx, ny)) continue;
            ni = ny * gasp_pkg::MAP_W + nx;
            if (wall_map[ni] || done_flag[ni]) continue;
            ng = g_cost[best] + 1;
            nf = ng + manhattan(nx, ny, gx, gy);
            if (open_flag[ni]) begin
               if (g_cost[ni] + manhattan(nx, ny, gx, gy) < nf) continue;
            end else begin
               open_n++;
            end
            open_flag[ni] = 1;
            g_cost[ni] = ng;
            came_dir[ni] = d;
         end
         done_flag[best] = 1;
      end
      return r;
   endfunction

   // Predict on each request transfer, compare on each result transfer.
   always @(posedge clock) begin
      route_type exp_r;
      if (reset) begin
         // The block comes out of reset with an open grid.
         fail_count = 0;
         route_queue.delete();
         foreach (wall_map[i]) wall_map[i] = 0;
      end else begin
         if (req_valid && !req_stall) begin
            if (req_func == gasp_pkg::FUNC_WRITE)
               wall_map[int'(req_cell_y) * gasp_pkg::MAP_W + int'(req_cell_x)] = req_blocked;
            else
               route_queue.insert(route_queue.size(),
                                  search_route(req_cell_x, req_cell_y,
                                               req_goal_x, req_goal_y));
         end
         if (rsp_valid && !rsp_stall) begin
            if (route_queue.size() == 0) begin
               $error("result transfer with no query outstanding");
               fail_count++;
            end else begin
               exp_r = route_queue.pop_front();
               if (rsp_status !== exp_r.status) begin
                  $error("status expected %0d actual %0d", exp_r.status, rsp_status);
                  fail_count++;
               end
               if (rsp_path_length !== exp_r.path_length) begin
                  $error("path_length expected %0d actual %0d",
                         exp_r.path_length, rsp_path_length);
                  fail_count++;
               end
               if (rsp_first_x !== exp_r.first_x) begin
                  $error("first_x expected %0d actual %0d", exp_r.first_x, rsp_first_x);
                  fail_count++;
               end
               if (rsp_first_y !== exp_r.first_y) begin
                  $error("first_y expected %0d actual %0d", exp_r.first_y, rsp_first_y);
                  fail_count++;
               end
            end
         end
      end
      pending = route_queue.size();
   end

endmodule

/* dv/grid_astar_path_search_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid path search testbench
// Runs directed queries on the corner cases of the search, starting from the
// open grid left by reset, then random mixes of map writes and nearby-goal
// queries under three idling patterns. The checker judges every result.
// ----------------------------------------------------------------------------
module grid_astar_path_search_tb;

   localparam int CYCLE_LIMIT = 1_000_000_000;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic       req_func;
   logic [4:0] req_cell_x;
   logic [4:0] req_cell_y;
   logic [4:0] req_goal_x;
   logic [4:0] req_goal_y;
   logic       req_blocked;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [1:0] rsp_status;
   logic [9:0] rsp_path_length;
   logic [4:0] rsp_first_x;
   logic [4:0] rsp_first_y;
   int         fail_count;
   int         pending;
   int         send_idle_pct;
   int         recv_idle_pct;
   int         cycle_count = 0;

   grid_astar_path_search DUT (.*);

   grid_astar_path_search_checker checker_inst (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Random result stall according to the current idling pattern.
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // Runaway guard.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL grid_astar_path_search");
         $finish;
      end
   end

   // Present one request and hold it until its transfer.
   task automatic send_req(logic func, int x, int y, int gx, int gy, logic blk);
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid   <= 1'b1;
      req_func    <= func;
      req_cell_x  <= 5'(x);
      req_cell_y  <= 5'(y);
      req_goal_x  <= 5'(gx);
      req_goal_y  <= 5'(gy);
      req_blocked <= blk;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic put_wall(int x, int y, logic blk);
      send_req(gasp_pkg::FUNC_WRITE, x, y, $urandom_range(31), $urandom_range(31), blk);
   endtask

   task automatic ask_route(int x, int y, int gx, int gy);
      send_req(gasp_pkg::FUNC_QUERY, x, y, gx, gy, 1'($urandom_range(1)));
   endtask

   // Hold the request side quiet until every query has answered.
   task automatic drain_routes();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   function automatic int clamp_cell(int v);
      return v < 0 ? 0 : (v > 31 ? 31 : v);
   endfunction

   // Random mix: mostly queries to nearby goals, some map writes.
   task automatic random_phase(int count);
      int x, y, span;
      for (int n = 0; n < count; n++) begin
         x = $urandom_range(31);
         y = $urandom_range(31);
         if ($urandom_range(99) < 30) begin
            put_wall(x, y, $urandom_range(99) < 25);
         end else begin
            span = ($urandom_range(9) == 0) ? 6 : 3;
            ask_route(x, y, clamp_cell(x + int'($urandom_range(2 * span)) - span),
                      clamp_cell(y + int'($urandom_range(2 * span)) - span));
         end
      end
   endtask

   initial begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_func    = gasp_pkg::FUNC_WRITE;
      req_cell_x  = '0;
      req_cell_y  = '0;
      req_goal_x  = '0;
      req_goal_y  = '0;
      req_blocked = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Start equal to goal at both corners.
      ask_route(0, 0, 0, 0);
      ask_route(31, 31, 31, 31);
      // Start walled in on all four sides: no path.
      put_wall(6, 5, 1'b1);
      put_wall(4, 5, 1'b1);
      put_wall(5, 6, 1'b1);
      put_wall(5, 4, 1'b1);
      ask_route(5, 5, 9, 9);
      // Blocked start is still expanded; a blocked goal is still reached.
      put_wall(5, 5, 1'b1);
      ask_route(5, 5, 5, 6);
      // Reopen one side and route out through it.
      put_wall(6, 5, 1'b0);
      put_wall(7, 5, 1'b0);
      ask_route(5, 5, 8, 5);
      // Searches along the map edges, where neighbors fall off the map.
      ask_route(0, 0, 1, 0);
      ask_route(31, 31, 30, 31);
      ask_route(31, 0, 28, 2);
      ask_route(0, 31, 6, 25);
      put_wall(31, 31, 1'b0);
      ask_route(30, 31, 31, 31);

      send_idle_pct = 21;
      recv_idle_pct = 81;
      random_phase(40);
      drain_routes();
      send_idle_pct = 81;
      recv_idle_pct = 21;
      random_phase(40);
      drain_routes();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      random_phase(40);

      drain_routes();
      repeat (20) @(posedge clock);
      if (fail_count == 0)
         $display("PASS grid_astar_path_search");
      else
         $display("FAIL grid_astar_path_search");
      $finish;
   end

endmodule

/* filelist.f */
rtl/gasp_pkg.sv
rtl/gasp_store.sv
rtl/grid_astar_path_search.sv
dv/grid_astar_path_search_checker.sv
dv/grid_astar_path_search_tb.sv
